// ----- rtl/rfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants for the rangefinder response frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int unsigned WinDepth = 7;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned DistW    = 32;

  localparam logic [ByteW-1:0] HdrFirst  = 8'hB4;
  localparam logic [ByteW-1:0] HdrSecond = 8'h69;
  localparam int unsigned      ErrBit    = 7;

  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] data;
  } cell_t;

  typedef cell_t [WinDepth-1:0] win_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic             is_error;
    logic [DistW-1:0] range_mm;
    logic [ByteW-1:0] fault_code;
  } result_t;

endpackage

// ----- rtl/rfp_cell.sv -----
// ----------------------------------------------------------------------------
// rfp_cell
// One window slot: holds a byte and its fill flag, takes its neighbor's value or clears.
// ----------------------------------------------------------------------------
module rfp_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfp_pkg::cell_ctrl_t ctrl_i,
  input  rfp_pkg::cell_t     cell_i,
  output rfp_pkg::cell_t     cell_o
);
  import rfp_pkg::*;

  logic             vld_q, vld_d;
  logic [ByteW-1:0] data_q, data_d;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    if (ctrl_i.clear) begin
      vld_d  = 1'b0;
      data_d = '0;
    end else if (ctrl_i.shift) begin
      vld_d  = cell_i.vld;
      data_d = cell_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign cell_o.vld  = vld_q;
  assign cell_o.data = data_q;

endmodule

// ----- rtl/rfp_decode.sv -----
// ----------------------------------------------------------------------------
// rfp_decode
// Frame match on the window plus incoming check byte, and result fields.
// ----------------------------------------------------------------------------
module rfp_decode (
  input  rfp_pkg::win_t    win_i,
  input  logic [7:0]       rx_byte_i,
  output rfp_pkg::result_t res_o
);
  import rfp_pkg::*;

  logic [ByteW-1:0] bcc;
  logic             err;

  always_comb begin
    bcc = '0;
    for (int unsigned k = 0; k < WinDepth; k++) begin
      bcc = bcc ^ win_i[k].data;
    end
  end

  assign err = win_i[2].data[ErrBit];

  assign res_o.hit = win_i[0].vld
                  && (win_i[0].data == HdrFirst)
                  && (win_i[1].data == HdrSecond)
                  && (bcc == rx_byte_i);
  assign res_o.is_error   = err;
  assign res_o.range_mm   = err ? '0
                          : {win_i[3].data, win_i[4].data, win_i[5].data, win_i[6].data};
  assign res_o.fault_code = err ? win_i[6].data : '0;

endmodule

// ----- rtl/rangefinder_response_frame_parser_top.sv -----
// ----------------------------------------------------------------------------
// rangefinder_response_frame_parser_top
// Sliding 8-byte frame detector for rangefinder responses with XOR check.
// ----------------------------------------------------------------------------
// Input channel: one received byte per request (rx_byte_i, last_of_buffer_i),
// taken when in_valid_i is high and in_stall_o is low. A byte flagged last
// ends the buffer; the window is emptied after it is checked.
// Output channel: one request per recognized frame (is_error_o,
// range_mm_o, fault_code_o), taken when out_valid_o is high and
// out_stall_i is low. Bytes that complete no frame give no request.
// Throughput: one byte per cycle unless in_stall_o is high, set by the shift
// of the seven-cell window and the parallel XOR/header match.
// Result: registered in the output register, or in the skid entry if that is held.
// Stall: an output register plus one skid entry; in_stall_o rises only
// when both hold results and clears the cycle after the output is taken.
// Reset: asynchronous, active low; empties the window and drops any
// pending results.
// ----------------------------------------------------------------------------
module rangefinder_response_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        last_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_error_o,
  output logic [31:0] range_mm_o,
  output logic [7:0]  fault_code_o
);
  import rfp_pkg::*;

  logic       in_take;
  logic       out_take;
  cell_ctrl_t ctrl;
  win_t       win;
  cell_t      feed;
  result_t    res;

  logic    out_vld_q, out_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  logic [WinDepth-1:0] vld_vec;

  assign in_take  = in_valid_i && !skid_vld_q;
  assign out_take = out_vld_q && !out_stall_i;

  assign ctrl.shift = in_take;
  assign ctrl.clear = in_take && last_of_buffer_i;

  assign feed.vld  = 1'b1;
  assign feed.data = rx_byte_i;

  for (genvar i = 0; i < WinDepth; i++) begin : g_cell
    if (i == WinDepth - 1) begin : g_head
      rfp_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .cell_i (feed),
        .cell_o (win[i])
      );
    end else begin : g_body
      rfp_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .cell_i (win[i+1]),
        .cell_o (win[i])
      );
    end
    assign vld_vec[i] = win[i].vld;
  end

  rfp_decode u_decode (
    .win_i     (win),
    .rx_byte_i (rx_byte_i),
    .res_o     (res)
  );

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (out_take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (in_take && res.hit) begin
      if (!out_vld_q || out_take) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o   = skid_vld_q;
  assign out_valid_o  = out_vld_q;
  assign is_error_o   = out_q.is_error;
  assign range_mm_o   = out_q.range_mm;
  assign fault_code_o = out_q.fault_code;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without output entry");

  a_fill_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_vec[WinDepth-2:0] & ~vld_vec[WinDepth-1:1]) == '0)
    else $error("window fill flags not contiguous");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && last_of_buffer_i) |=> (vld_vec == '0))
    else $error("window not empty after last byte");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result lost or changed");
`endif

endmodule
